// ===== hdl/clnw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clnw_pkg
// Types, codes and constant tables shared by the character LCD nibble writer.
// ----------------------------------------------------------------------------
package clnw_pkg;

   localparam logic [1:0] CMD_INIT  = 2'd0;
   localparam logic [1:0] CMD_INSTR = 2'd1;
   localparam logic [1:0] CMD_DATA  = 2'd2;
   localparam logic [1:0] CMD_CURSOR = 2'd3;

   localparam logic [5:0] POWERUP_MS  = 6'd40;
   localparam logic [5:0] STEP_MS     = 6'd1;
   localparam logic [7:0] CURSOR_BASE = 8'h80;
   localparam logic [7:0] ROW1_OFFSET = 8'h40;

   localparam logic [3:0] PRE_LAST   = 4'd13;
   localparam logic [3:0] BYTE_LAST  = 4'd5;
   localparam logic [2:0] SETUP_LAST = 3'd4;

   typedef logic [7:0] setup_rom_type [0:4];
   localparam setup_rom_type SETUP_BYTES = '{8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POWER,
      ST_PRE,
      ST_SETUP,
      ST_BYTE
   } state_type;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_POWER,
      KIND_PRE,
      KIND_SETUP,
      KIND_BYTE
   } kind_type;

   typedef struct packed {
      logic     load;
      kind_type kind;
      logic     last;
   } ctl_cmd_type;

   typedef struct packed {
      logic pre_done;
      logic byte_done;
      logic setup_done;
   } dp_stat_type;

   typedef struct packed {
      logic       enable;
      logic [3:0] nibble;
      logic [5:0] wait_ms;
   } pin_step_type;

   // wake-up script after the power-up wait: nibble 3, hold 5 ms, nibble 3,
   // hold 1 ms, nibble 3, nibble 2
   function automatic pin_step_type pre_step(input logic [3:0] idx);
      pin_step_type s;
      s.enable  = 1'b0;
      s.nibble  = 4'h3;
      s.wait_ms = STEP_MS;
      case (idx)
         4'd1, 4'd5, 4'd9: s.enable = 1'b1;
         4'd3:             s.wait_ms = 6'd5;
         4'd11, 4'd13:     s.nibble = 4'h2;
         4'd12: begin
            s.nibble = 4'h2;
            s.enable = 1'b1;
         end
         default: s.enable = 1'b0;
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/clnw_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clnw_ctrl
// Sequencer: walks power-up, wake-up script, set-up bytes or a single byte.
// ----------------------------------------------------------------------------
module clnw_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [1:0]            req_command,
   input  wire clnw_pkg::dp_stat_type stat,
   output logic                       busy,
   output clnw_pkg::ctl_cmd_type      cmd
);

   clnw_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clnw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd.load = 1'b0;
      cmd.kind = clnw_pkg::KIND_NONE;
      cmd.last = 1'b0;
      busy     = 1'b1;
      unique case (state_ff)
         clnw_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = (req_command == clnw_pkg::CMD_INIT) ?
                          clnw_pkg::ST_POWER : clnw_pkg::ST_BYTE;
            end
         end
         clnw_pkg::ST_POWER: begin
            cmd.kind = clnw_pkg::KIND_POWER;
            state_in = clnw_pkg::ST_PRE;
         end
         clnw_pkg::ST_PRE: begin
            cmd.kind = clnw_pkg::KIND_PRE;
            if (stat.pre_done) begin
               state_in = clnw_pkg::ST_SETUP;
            end
         end
         clnw_pkg::ST_SETUP: begin
            cmd.kind = clnw_pkg::KIND_SETUP;
            if (stat.byte_done && stat.setup_done) begin
               cmd.last = 1'b1;
               state_in = clnw_pkg::ST_IDLE;
            end
         end
         clnw_pkg::ST_BYTE: begin
            cmd.kind = clnw_pkg::KIND_BYTE;
            if (stat.byte_done) begin
               cmd.last = 1'b1;
               state_in = clnw_pkg::ST_IDLE;
            end
         end
         default: state_in = clnw_pkg::ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ===== hdl/clnw_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clnw_dp
// Datapath: request byte, step counters and the registered pin step.
// ----------------------------------------------------------------------------
module clnw_dp #(
   parameter int NUM_ROWS = 2,
   parameter int NUM_COLS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire clnw_pkg::ctl_cmd_type cmd,
   input  wire logic [1:0]            req_command,
   input  wire logic [7:0]            req_byte_value,
   input  wire logic [1:0]            req_row,
   input  wire logic [5:0]            req_col,
   output clnw_pkg::dp_stat_type      stat,
   output logic                       rsp_strobe,
   output logic                       rsp_reg_select,
   output logic                       rsp_enable,
   output logic [3:0]                 rsp_data_nibble,
   output logic [5:0]                 rsp_wait_ms,
   output logic                       rsp_last
);

   localparam logic [5:0] MaxCol = 6'(NUM_COLS - 1);
   localparam logic       MultiRow = (NUM_ROWS > 1);

   logic [7:0] byte_ff, byte_in;
   logic       rs_ff, rs_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [2:0] setup_ff, setup_in;

   logic       strobe_ff, strobe_in;
   logic       sel_ff, sel_in;
   logic       en_ff, en_in;
   logic [3:0] nib_ff, nib_in;
   logic [5:0] wait_ff, wait_in;
   logic       last_ff, last_in;

   logic [5:0] col_clamp;
   logic [7:0] cursor_addr;
   logic [7:0] src_byte;
   logic       low_half;
   logic [3:0] phase_cnt;
   clnw_pkg::pin_step_type pre;

   assign col_clamp   = (req_col > MaxCol) ? MaxCol : req_col;
   assign cursor_addr = clnw_pkg::CURSOR_BASE
                        + ((MultiRow && (req_row != 2'd0)) ? clnw_pkg::ROW1_OFFSET : 8'h00)
                        + {2'b00, col_clamp};

   assign stat.pre_done   = (cnt_ff == clnw_pkg::PRE_LAST);
   assign stat.byte_done  = (cnt_ff == clnw_pkg::BYTE_LAST);
   assign stat.setup_done = (setup_ff == clnw_pkg::SETUP_LAST);

   assign pre       = clnw_pkg::pre_step(cnt_ff);
   assign low_half  = (cnt_ff >= 4'd3);
   assign phase_cnt = low_half ? (cnt_ff - 4'd3) : cnt_ff;
   assign src_byte  = (cmd.kind == clnw_pkg::KIND_SETUP) ?
                      clnw_pkg::SETUP_BYTES[setup_ff] : byte_ff;

   always_comb begin
      byte_in  = byte_ff;
      rs_in    = rs_ff;
      cnt_in   = cnt_ff;
      setup_in = setup_ff;
      if (cmd.load) begin
         cnt_in   = 4'd0;
         setup_in = 3'd0;
         rs_in    = (req_command == clnw_pkg::CMD_DATA);
         byte_in  = (req_command == clnw_pkg::CMD_CURSOR) ? cursor_addr : req_byte_value;
      end else begin
         case (cmd.kind)
            clnw_pkg::KIND_PRE:
               cnt_in = stat.pre_done ? 4'd0 : cnt_ff + 4'd1;
            clnw_pkg::KIND_SETUP: begin
               cnt_in = stat.byte_done ? 4'd0 : cnt_ff + 4'd1;
               if (stat.byte_done) begin
                  setup_in = setup_ff + 3'd1;
               end
            end
            clnw_pkg::KIND_BYTE:
               cnt_in = stat.byte_done ? 4'd0 : cnt_ff + 4'd1;
            default: cnt_in = cnt_ff;
         endcase
      end
   end

   always_comb begin
      strobe_in = (cmd.kind != clnw_pkg::KIND_NONE);
      last_in   = cmd.last;
      sel_in    = 1'b0;
      en_in     = 1'b0;
      nib_in    = 4'h0;
      wait_in   = clnw_pkg::STEP_MS;
      case (cmd.kind)
         clnw_pkg::KIND_POWER: wait_in = clnw_pkg::POWERUP_MS;
         clnw_pkg::KIND_PRE: begin
            en_in   = pre.enable;
            nib_in  = pre.nibble;
            wait_in = pre.wait_ms;
         end
         clnw_pkg::KIND_SETUP, clnw_pkg::KIND_BYTE: begin
            sel_in = (cmd.kind == clnw_pkg::KIND_BYTE) && rs_ff;
            en_in  = (phase_cnt == 4'd1);
            nib_in = low_half ? src_byte[3:0] : src_byte[7:4];
         end
         default: wait_in = clnw_pkg::STEP_MS;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
         cnt_ff    <= 4'd0;
         setup_ff  <= 3'd0;
      end else begin
         strobe_ff <= strobe_in;
         cnt_ff    <= cnt_in;
         setup_ff  <= setup_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      rs_ff   <= rs_in;
      sel_ff  <= sel_in;
      en_ff   <= en_in;
      nib_ff  <= nib_in;
      wait_ff <= wait_in;
      last_ff <= last_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_reg_select  = sel_ff;
   assign rsp_enable      = en_ff;
   assign rsp_data_nibble = nib_ff;
   assign rsp_wait_ms     = wait_ff;
   assign rsp_last        = last_ff;

endmodule
`default_nettype wire

// ===== hdl/char_lcd_nibble_writer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer
// 4-bit character LCD interface: one request in, a train of pin steps out.
// ----------------------------------------------------------------------------
// Latency: start is taken into the sequencer state register, and the first
// step then comes out of the pin-step output registers. Throughput: one step
// per cycle. A new item is taken the cycle busy falls.
// Results cannot be stalled. Synchronous reset returns the sequencer to
// idle and drops the strobe; nothing else is kept between items.
module char_lcd_nibble_writer #(
   parameter int NUM_ROWS = 2,
   parameter int NUM_COLS = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_command,
   input  wire logic [7:0] req_byte_value,
   input  wire logic [1:0] req_row,
   input  wire logic [5:0] req_col,
   output logic            rsp_strobe,
   output logic            rsp_reg_select,
   output logic            rsp_enable,
   output logic [3:0]      rsp_data_nibble,
   output logic [5:0]      rsp_wait_ms,
   output logic            rsp_last
);

   clnw_pkg::ctl_cmd_type cmd;
   clnw_pkg::dp_stat_type stat;

   clnw_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .stat        (stat),
      .busy        (busy),
      .cmd         (cmd)
   );

   clnw_dp #(
      .NUM_ROWS (NUM_ROWS),
      .NUM_COLS (NUM_COLS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_command     (req_command),
      .req_byte_value  (req_byte_value),
      .req_row         (req_row),
      .req_col         (req_col),
      .stat            (stat),
      .rsp_strobe      (rsp_strobe),
      .rsp_reg_select  (rsp_reg_select),
      .rsp_enable      (rsp_enable),
      .rsp_data_nibble (rsp_data_nibble),
      .rsp_wait_ms     (rsp_wait_ms),
      .rsp_last        (rsp_last)
   );

endmodule
`default_nettype wire

// ===== tb/char_lcd_nibble_writer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_tb
// Sends init, instruction, data and cursor requests through the start/busy
// handshake and checks every pin step the block puts out against a local
// step generator, with random sender gaps and full drain pauses.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_tb;

   localparam int NUM_ROWS     = 2;
   localparam int NUM_COLS     = 16;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 10;
   localparam int MAX_REPORTS  = 10;

   localparam logic [5:0] POWER_UP_HOLD = 6'd40;
   localparam logic [7:0] INIT_BYTES [5] = '{8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};

   typedef struct packed {
      logic       rs;
      logic       en;
      logic [3:0] nibble;
      logic [5:0] wait_ms;
      logic       last;
   } lcd_step_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic [1:0] req_command = clnw_pkg::CMD_INIT;
   logic [7:0] req_byte_value = 8'h00;
   logic [1:0] req_row = 2'd0;
   logic [5:0] req_col = 6'd0;
   logic       busy;
   logic       rsp_strobe;
   logic       rsp_reg_select;
   logic       rsp_enable;
   logic [3:0] rsp_data_nibble;
   logic [5:0] rsp_wait_ms;
   logic       rsp_last;

   lcd_step_type pending_steps[$];
   int         mismatches = 0;
   int         steps_checked = 0;
   int         requests_sent = 0;
   int         cmd_count [4] = '{0, 0, 0, 0};
   int         cycles = 0;

   char_lcd_nibble_writer #(
      .NUM_ROWS(NUM_ROWS),
      .NUM_COLS(NUM_COLS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_byte_value (req_byte_value),
      .req_row        (req_row),
      .req_col        (req_col),
      .rsp_strobe     (rsp_strobe),
      .rsp_reg_select (rsp_reg_select),
      .rsp_enable     (rsp_enable),
      .rsp_data_nibble(rsp_data_nibble),
      .rsp_wait_ms    (rsp_wait_ms),
      .rsp_last       (rsp_last)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d steps pending", cycles,
                  pending_steps.size());
         $display("FAIL char_lcd_nibble_writer");
         $finish;
      end
   end

   // ---- step generator ----
   task automatic push_step(input logic rs, input logic en, input logic [3:0] nib,
                            input logic [5:0] ms);
      lcd_step_type s;
      s.rs      = rs;
      s.en      = en;
      s.nibble  = nib;
      s.wait_ms = ms;
      s.last    = 1'b0;
      pending_steps.push_back(s);
   endtask

   task automatic push_nibble(input logic rs, input logic [3:0] nib);
      push_step(rs, 1'b0, nib, 6'd1);
      push_step(rs, 1'b1, nib, 6'd1);
      push_step(rs, 1'b0, nib, 6'd1);
   endtask

   task automatic push_byte(input logic rs, input logic [7:0] b);
      push_nibble(rs, b[7:4]);
      push_nibble(rs, b[3:0]);
   endtask

   task automatic predict_pin_steps(input logic [1:0] cmd, input logic [7:0] bv,
                                    input logic [1:0] row, input logic [5:0] col);
      int unsigned r;
      int unsigned c;
      int          i;
      logic [7:0]  addr;
      r = row;
      c = col;
      if (r > NUM_ROWS - 1) r = NUM_ROWS - 1;
      if (c > NUM_COLS - 1) c = NUM_COLS - 1;
      case (cmd)
         clnw_pkg::CMD_INIT: begin
            push_step(1'b0, 1'b0, 4'h0, POWER_UP_HOLD);
            push_nibble(1'b0, 4'h3);
            push_step(1'b0, 1'b0, 4'h3, 6'd5);
            push_nibble(1'b0, 4'h3);
            push_step(1'b0, 1'b0, 4'h3, 6'd1);
            push_nibble(1'b0, 4'h3);
            push_nibble(1'b0, 4'h2);
            for (i = 0; i < 5; i++) push_byte(1'b0, INIT_BYTES[i]);
         end
         clnw_pkg::CMD_INSTR: push_byte(1'b0, bv);
         clnw_pkg::CMD_DATA:  push_byte(1'b1, bv);
         default: begin
            addr = 8'h80 + ((r != 0) ? 8'h40 : 8'h00) + 8'(c);
            push_byte(1'b0, addr);
         end
      endcase
      pending_steps[pending_steps.size() - 1].last = 1'b1;
   endtask

   // ---- step checker ----
   always @(posedge clock) begin : check_steps
      lcd_step_type got;
      lcd_step_type want;
      if (!reset && rsp_strobe) begin
         got = '{rsp_reg_select, rsp_enable, rsp_data_nibble, rsp_wait_ms, rsp_last};
         if (pending_steps.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: step with none pending: rs=%0d e=%0d d=%h ms=%0d last=%0d",
                        got.rs, got.en, got.nibble, got.wait_ms, got.last);
         end else begin
            want = pending_steps.pop_front();
            steps_checked++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"ERROR: step %0d exp rs=%0d e=%0d d=%h ms=%0d last=%0d,",
                            " got rs=%0d e=%0d d=%h ms=%0d last=%0d"}, steps_checked,
                           want.rs, want.en, want.nibble, want.wait_ms, want.last,
                           got.rs, got.en, got.nibble, got.wait_ms, got.last);
            end
         end
      end
   end

   // ---- sender ----
   task automatic send_request(input logic [1:0] cmd, input logic [7:0] bv,
                               input logic [1:0] row, input logic [5:0] col);
      @(negedge clock);
      start          = 1'b1;
      req_command    = cmd;
      req_byte_value = bv;
      req_row        = row;
      req_col        = col;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_pin_steps(cmd, bv, row, col);
      requests_sent++;
      cmd_count[cmd]++;
   endtask

   task automatic sender_gap(input int pct);
      int n;
      n = 0;
      if ($urandom_range(99) < pct) begin
         n = ($urandom_range(3) == 0) ? $urandom_range(8, 50) : $urandom_range(1, 8);
         @(negedge clock);
         start = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start = 1'b0;
      while (pending_steps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---- tests ----
   task automatic test_init();
      send_request(clnw_pkg::CMD_INIT, 8'hFF, 2'd3, 6'd63);
      send_request(clnw_pkg::CMD_INIT, 8'h00, 2'd0, 6'd0);
   endtask

   task automatic test_write_instruction();
      send_request(clnw_pkg::CMD_INSTR, 8'h00, 2'd3, 6'd63);
      send_request(clnw_pkg::CMD_INSTR, 8'hFF, 2'd0, 6'd0);
      send_request(clnw_pkg::CMD_INSTR, 8'h5A, 2'd1, 6'd21);
      send_request(clnw_pkg::CMD_INSTR, 8'hA5, 2'd2, 6'd42);
   endtask

   task automatic test_write_data();
      send_request(clnw_pkg::CMD_DATA, 8'h00, 2'd0, 6'd0);
      send_request(clnw_pkg::CMD_DATA, 8'hFF, 2'd3, 6'd63);
      send_request(clnw_pkg::CMD_DATA, 8'h41, 2'd1, 6'd16);
      send_request(clnw_pkg::CMD_DATA, 8'hBE, 2'd2, 6'd15);
   endtask

   task automatic test_set_cursor();
      send_request(clnw_pkg::CMD_CURSOR, 8'h00, 2'd0, 6'd0);
      send_request(clnw_pkg::CMD_CURSOR, 8'hFF, 2'd0, 6'd15);
      send_request(clnw_pkg::CMD_CURSOR, 8'h00, 2'd1, 6'd0);
      send_request(clnw_pkg::CMD_CURSOR, 8'hFF, 2'd1, 6'd15);
      // row and column past the panel are clamped
      send_request(clnw_pkg::CMD_CURSOR, 8'h00, 2'd2, 6'd16);
      send_request(clnw_pkg::CMD_CURSOR, 8'hFF, 2'd3, 6'd63);
      send_request(clnw_pkg::CMD_CURSOR, 8'h00, 2'd0, 6'd63);
      send_request(clnw_pkg::CMD_CURSOR, 8'hFF, 2'd3, 6'd0);
   endtask

   task automatic test_drain_pause();
      send_request(clnw_pkg::CMD_INSTR, 8'h01, 2'd0, 6'd0);
      wait_drained();
      send_request(clnw_pkg::CMD_DATA, 8'h7E, 2'd1, 6'd1);
   endtask

   task automatic test_random(input int count, input int gap_pct);
      int         k;
      logic [1:0] cmd;
      logic [7:0] bv;
      logic [1:0] row;
      logic [5:0] col;
      for (k = 0; k < count; k++) begin
         cmd = ($urandom_range(19) == 0) ? clnw_pkg::CMD_INIT : 2'($urandom_range(1, 3));
         bv  = 8'($urandom);
         row = 2'($urandom);
         col = ($urandom_range(1) == 0) ? 6'($urandom) : 6'($urandom_range(12, 20));
         send_request(cmd, bv, row, col);
         if ($urandom_range(49) == 0) wait_drained();
         else sender_gap(gap_pct);
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_init();
      test_write_instruction();
      test_write_data();
      test_set_cursor();
      test_drain_pause();
      test_random(113, 13);
      test_random(113, 60);
      test_random(114, 0);

      wait_drained();
      $display("Run covered %0d requests: %0d init, %0d instruction, %0d data, %0d cursor.",
               requests_sent, cmd_count[clnw_pkg::CMD_INIT], cmd_count[clnw_pkg::CMD_INSTR],
               cmd_count[clnw_pkg::CMD_DATA], cmd_count[clnw_pkg::CMD_CURSOR]);
      $display("Checked %0d pin steps with sender gaps of varied length; %0d mismatches.",
               steps_checked, mismatches);
      if (mismatches == 0 && pending_steps.size() == 0) begin
         $display("PASS char_lcd_nibble_writer");
      end else begin
         $display("FAIL char_lcd_nibble_writer");
      end
      $finish;
   end

endmodule
